/* hdl/asc_pkg.sv */
`timescale 1ns / 1ps

package asc_pkg;

   localparam int AXIS_W    = 10;
   localparam int MAG_W     = 11;
   localparam int CFG_W     = 10;
   localparam int WEIGHT_W  = 10;
   localparam int MARGIN_W  = 10;
   localparam int CONFIRM_W = 4;
   localparam int STEP_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W     = 22;
   localparam int AVG_SHIFT = 10;
   localparam int AXIS_COUNT = 3;

   localparam logic [MAG_W-1:0]     MAG_SAT      = 11'd2047;
   localparam logic [MAG_W-1:0]     MAG_LIMIT    = 11'd1771;
   localparam logic [MAG_W-1:0]     VALLEY_RESET = 11'd1024;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_FULL  = 10'd1023;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET = 10'd128;
   localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 10'd25;
   localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 4'd5;
   localparam logic [CONFIRM_W-1:0] HOLD_MAX     = 4'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef enum logic [1:0] {
      PH_SEEK_MAX = 2'd0,
      PH_FALL     = 2'd1,
      PH_SEEK_MIN = 2'd2,
      PH_RISE     = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_AVERAGE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [AXIS_W-1:0] accel_x;
      logic [AXIS_W-1:0] accel_y;
      logic [AXIS_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude;
      logic [MAG_W-1:0]  average;
      logic [STEP_W-1:0] step_count;
      logic              step_seen;
      logic [1:0]        tracker_phase;
   } rsp_type;

   typedef struct packed {
      logic       square;
      logic       first_sq;
      logic [1:0] axis;
      logic       root;
      logic       av_load;
      logic       av_step;
      logic       commit;
   } ctl_type;

endpackage

/* hdl/asc_root.sv */
`timescale 1ns / 1ps

module asc_root #(
   parameter int AXIS_BITS = 10
) (
   input  logic                       clock,
   input  asc_pkg::ctl_type           ctl,
   input  logic [AXIS_BITS-1:0]       x,
   input  logic [AXIS_BITS-1:0]       y,
   input  logic [AXIS_BITS-1:0]       z,
   output logic [asc_pkg::MAG_W-1:0]  mag
);
   import asc_pkg::*;

   localparam int PROD_W = 2 * AXIS_BITS;
   localparam int SUM_W  = 2 * AXIS_BITS + 2;
   localparam int ROOT_W = AXIS_BITS + 1;
   localparam int REM_W  = ROOT_W + 1;

   logic [AXIS_BITS-1:0]     operand;
   logic [PROD_W-1:0]        square;
   logic [SUM_W-1:0]         rad_ff, rad_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [REM_W+1:0]         rem_sh, trial;
   logic [ROOT_W+MAG_W-1:0]  root_ext;
   logic [ROOT_W-1:0]        root_hi;

   always_comb begin
      unique case (ctl.axis)
         AXIS_X:  operand = x;
         AXIS_Y:  operand = y;
         default: operand = z;
      endcase
   end

   assign square = PROD_W'(operand) * PROD_W'(operand);

   // restoring root, two radicand bits in, one root bit out per cycle
   assign rem_sh = {rem_ff, rad_ff[SUM_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.square) begin
         rad_in  = (ctl.first_sq ? SUM_W'(0) : rad_ff) + SUM_W'(square);
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.root) begin
         rad_in = {rad_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_ext = {MAG_W'(0), root_ff};
   assign root_hi  = root_ext[ROOT_W+MAG_W-1:MAG_W];
   assign mag      = (|root_hi) ? MAG_SAT : root_ext[MAG_W-1:0];

endmodule

/* hdl/asc_ewma.sv */
`timescale 1ns / 1ps

module asc_ewma (
   input  logic                          clock,
   input  logic                          reset,
   input  asc_pkg::ctl_type              ctl,
   input  logic                          seeded,
   input  logic [asc_pkg::WEIGHT_W-1:0]  weight,
   input  logic [asc_pkg::MAG_W-1:0]     mag,
   output logic [asc_pkg::MAG_W-1:0]     avg_new
);
   import asc_pkg::*;

   logic [MAG_W-1:0]    avg_ff, avg_in;
   logic [MAG_W-1:0]    mag_sh_ff, mag_sh_in;
   logic [MAG_W-1:0]    avg_sh_ff, avg_sh_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [WEIGHT_W-1:0] beta;
   logic [WEIGHT_W-1:0] term_new, term_old;

   assign beta     = WEIGHT_FULL - weight;
   assign term_new = mag_sh_ff[MAG_W-1] ? weight : '0;
   assign term_old = avg_sh_ff[MAG_W-1] ? beta : '0;

   // MSB-first shift-add over the magnitude and average bits
   always_comb begin
      mag_sh_in = mag_sh_ff;
      avg_sh_in = avg_sh_ff;
      acc_in    = acc_ff;
      if (ctl.av_load) begin
         mag_sh_in = mag;
         avg_sh_in = avg_ff;
         acc_in    = '0;
      end else if (ctl.av_step) begin
         mag_sh_in = {mag_sh_ff[MAG_W-2:0], 1'b0};
         avg_sh_in = {avg_sh_ff[MAG_W-2:0], 1'b0};
         acc_in    = {acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(term_new) + ACC_W'(term_old);
      end
   end

   assign avg_new = seeded ? acc_ff[AVG_SHIFT +: MAG_W] : mag;
   assign avg_in  = ctl.commit ? avg_new : avg_ff;

   always_ff @(posedge clock) begin
      mag_sh_ff <= mag_sh_in;
      avg_sh_ff <= avg_sh_in;
      acc_ff    <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

endmodule

/* hdl/asc_track.sv */
`timescale 1ns / 1ps

module asc_track (
   input  logic                           clock,
   input  logic                           reset,
   input  asc_pkg::ctl_type               ctl,
   input  logic                           seeded,
   input  logic [asc_pkg::MAG_W-1:0]      mag,
   input  logic [asc_pkg::MAG_W-1:0]      avg,
   input  logic [asc_pkg::MARGIN_W-1:0]   margin,
   input  logic [asc_pkg::CONFIRM_W-1:0]  confirm,
   output logic [asc_pkg::STEP_W-1:0]     steps_next,
   output logic                           seen,
   output asc_pkg::phase_type             phase_next
);
   import asc_pkg::*;

   localparam int WIDE_W = MAG_W + 1;

   phase_type            phase_ff;
   logic [MAG_W-1:0]     peak_ff, peak_in;
   logic [MAG_W-1:0]     valley_ff, valley_in;
   logic [CONFIRM_W-1:0] hold_ff, hold_in;
   logic [STEP_W-1:0]    steps_ff;
   logic [CONFIRM_W-1:0] hold_inc;
   logic                 hold_done;
   logic                 fall_cross;
   logic                 rise_cross;

   assign hold_inc   = (hold_ff == HOLD_MAX) ? HOLD_MAX : hold_ff + 4'd1;
   assign hold_done  = hold_inc >= confirm;
   assign fall_cross = (MAG_W'(margin) > avg) || (mag < avg - MAG_W'(margin));
   assign rise_cross = WIDE_W'(mag) > (WIDE_W'(avg) + WIDE_W'(margin));

   always_comb begin
      phase_next = phase_ff;
      peak_in    = peak_ff;
      valley_in  = valley_ff;
      hold_in    = hold_ff;
      steps_next = steps_ff;
      seen       = 1'b0;
      if (seeded) begin
         unique case (phase_ff)
            PH_SEEK_MAX: begin
               if (mag > peak_ff) begin
                  peak_in = mag;
                  hold_in = '0;
               end else begin
                  hold_in = hold_inc;
                  if (hold_done) begin
                     phase_next = PH_FALL;
                  end
               end
            end
            PH_FALL: begin
               if (mag > peak_ff) begin
                  peak_in    = mag;
                  hold_in    = '0;
                  phase_next = PH_SEEK_MAX;
               end else if (fall_cross) begin
                  steps_next = steps_ff + 32'd1;
                  seen       = 1'b1;
                  valley_in  = VALLEY_RESET;
                  hold_in    = '0;
                  phase_next = PH_SEEK_MIN;
               end
            end
            PH_SEEK_MIN: begin
               if (mag < valley_ff) begin
                  valley_in = mag;
                  hold_in   = '0;
               end else begin
                  hold_in = hold_inc;
                  if (hold_done) begin
                     phase_next = PH_RISE;
                  end
               end
            end
            PH_RISE: begin
               if (mag < valley_ff) begin
                  valley_in  = mag;
                  hold_in    = '0;
                  phase_next = PH_SEEK_MIN;
               end else if (rise_cross) begin
                  steps_next = steps_ff + 32'd1;
                  seen       = 1'b1;
                  peak_in    = '0;
                  hold_in    = '0;
                  phase_next = PH_SEEK_MAX;
               end
            end
            default: begin
               phase_next = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK_MAX;
         peak_ff   <= '0;
         valley_ff <= VALLEY_RESET;
         hold_ff   <= '0;
         steps_ff  <= '0;
      end else if (ctl.commit) begin
         phase_ff  <= phase_next;
         peak_ff   <= peak_in;
         valley_ff <= valley_in;
         hold_ff   <= hold_in;
         steps_ff  <= steps_next;
      end
   end

endmodule

/* hdl/accelerometer_step_counter_core.sv */
`timescale 1ns / 1ps

// Step counter for a three-axis accelerometer. Each accepted transaction carries one
// sample per axis and returns one result: the floor square root of the sum of squares,
// the updated moving average, the running step count, a step flag and the tracker phase.
// One transaction is worked on at a time; the next is taken only after the previous
// result is registered. The work runs in order: square-and-add of the three axes on
// one shared multiplier, the bit-serial root (one root bit per cycle), the bit-serial
// average (one magnitude bit per cycle) and the tracker update, which waits while an
// earlier result is still stalled. The result register lets a new transaction start
// while the previous result is still stalled. Write the control registers only while
// idle.
module accelerometer_step_counter_core #(
   parameter int AXIS_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  asc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output asc_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [asc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asc_pkg::CFG_W-1:0]      csr_wdata
);
   import asc_pkg::*;

   localparam int IN_W   = (AXIS_BITS < AXIS_W) ? AXIS_BITS : AXIS_W;
   localparam int ROOT_W = AXIS_BITS + 1;
   localparam int STEPS  = (ROOT_W > MAG_W + 1) ? ROOT_W : MAG_W + 1;
   localparam int CNT_W  = $clog2(STEPS);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   ctl_type              ctl;
   logic [AXIS_BITS-1:0] x_ff, y_ff, z_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [MARGIN_W-1:0]  margin_ff;
   logic [CONFIRM_W-1:0] confirm_ff;
   logic                 seeded_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;
   logic                 req_take;
   logic                 out_free;
   logic                 sq_last, root_last, avg_last;
   logic [MAG_W-1:0]     mag;
   logic [MAG_W-1:0]     avg_new;
   logic [STEP_W-1:0]    steps_next;
   logic                 seen;
   phase_type            phase_next;

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sq_last   = cnt_ff == CNT_W'(AXIS_COUNT - 1);
   assign root_last = cnt_ff == CNT_W'(ROOT_W - 1);
   assign avg_last  = cnt_ff == CNT_W'(MAG_W);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:  if (sq_last) state_in = ST_ROOT;
         ST_ROOT:    if (root_last) state_in = ST_AVERAGE;
         ST_AVERAGE: if (avg_last) state_in = ST_COMMIT;
         ST_COMMIT:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
         end
         ST_SQUARE: begin
            ctl.square   = 1'b1;
            ctl.first_sq = cnt_ff == '0;
            ctl.axis     = cnt_ff[1:0];
            cnt_in       = sq_last ? '0 : cnt_ff + 1'b1;
         end
         ST_ROOT: begin
            ctl.root = 1'b1;
            cnt_in   = root_last ? '0 : cnt_ff + 1'b1;
         end
         ST_AVERAGE: begin
            ctl.av_load = cnt_ff == '0;
            ctl.av_step = cnt_ff != '0;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_COMMIT: begin
            ctl.commit = out_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff <= AXIS_BITS'(req_data.accel_x[IN_W-1:0]);
         y_ff <= AXIS_BITS'(req_data.accel_y[IN_W-1:0]);
         z_ff <= AXIS_BITS'(req_data.accel_z[IN_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= WEIGHT_RESET;
         margin_ff  <= MARGIN_RESET;
         confirm_ff <= CONFIRM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WEIGHT:  weight_ff  <= csr_wdata[WEIGHT_W-1:0];
            CSR_MARGIN:  margin_ff  <= csr_wdata[MARGIN_W-1:0];
            CSR_CONFIRM: confirm_ff <= csr_wdata[CONFIRM_W-1:0];
            default:     weight_ff  <= weight_ff;
         endcase
      end
   end

   asc_root #(
      .AXIS_BITS (AXIS_BITS)
   ) u_root (
      .clock (clock),
      .ctl   (ctl),
      .x     (x_ff),
      .y     (y_ff),
      .z     (z_ff),
      .mag   (mag)
   );

   asc_ewma u_ewma (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .seeded  (seeded_ff),
      .weight  (weight_ff),
      .mag     (mag),
      .avg_new (avg_new)
   );

   asc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .seeded     (seeded_ff),
      .mag        (mag),
      .avg        (avg_new),
      .margin     (margin_ff),
      .confirm    (confirm_ff),
      .steps_next (steps_next),
      .seen       (seen),
      .phase_next (phase_next)
   );

   assign rsp_valid_in = ctl.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.commit) begin
            seeded_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_data_ff.magnitude     <= mag;
         rsp_data_ff.average       <= avg_new;
         rsp_data_ff.step_count    <= steps_next;
         rsp_data_ff.step_seen     <= seen;
         rsp_data_ff.tracker_phase <= phase_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/asc_checker.sv */
`timescale 1ns / 1ps

module asc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input asc_pkg::rsp_type  rsp_data
);
   import asc_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   a_step_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_seen |->
         rsp_data.tracker_phase == PH_SEEK_MAX || rsp_data.tracker_phase == PH_SEEK_MIN)
      else $error("step reported in a crossing phase");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.magnitude <= MAG_LIMIT && rsp_data.average <= MAG_LIMIT)
      else $error("magnitude or average out of range");

endmodule

bind accelerometer_step_counter_core asc_checker u_asc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
